FILE: rtl/multi_rate_tick_timer_unit_macros.svh
// Assertion macros used by the timer top level.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef MULTI_RATE_TICK_TIMER_UNIT_MACROS_SVH
`define MULTI_RATE_TICK_TIMER_UNIT_MACROS_SVH

// same-cycle implication
`define MRTT_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MRTT_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/mrtt_pkg.sv
// Shared types, codes and residue helpers for the multi-rate tick timer.
// No dependencies; used by mrtt_count and the top level.
package mrtt_pkg;

	typedef enum logic [2:0] {
		REQ_CHECK   = 3'd0,
		REQ_RESTART = 3'd1,
		REQ_CLEAR   = 3'd2,
		REQ_ENABLE  = 3'd3,
		REQ_DISABLE = 3'd4
	} req_t;

	// rate bit positions in the enable and ready masks
	localparam int unsigned RATE_1MS   = 0;
	localparam int unsigned RATE_10MS  = 1;
	localparam int unsigned RATE_100MS = 2;
	localparam int unsigned RATE_1S    = 3;
	localparam int unsigned RATE_10S   = 4;
	localparam int unsigned RATE_1MIN  = 5;

	localparam logic [9:0]  MS_PER_SEC   = 10'd1000;
	localparam logic [3:0]  SEC_PER_10S  = 4'd10;
	localparam logic [5:0]  SEC_PER_MIN  = 6'd60;

	// counter state after a request, as carried down the pipeline
	typedef struct packed {
		logic        check;
		logic [5:0]  en;
		logic [9:0]  step;
		logic [31:0] left;
		logic [31:0] count;
		logic [9:0]  ms_r;
		logic [22:0] sec;
		logic [3:0]  sec_m10;
		logic [5:0]  sec_m60;
	} snap_t;

	// x % 10 for x below 1024, reciprocal 205 / 2^11
	function automatic logic [3:0] mod10(input logic [9:0] x);
		logic [17:0] p;
		logic [6:0]  q;
		logic [9:0]  r;
		p = 18'(x) * 18'd205;
		q = p[17:11];
		r = x - 10'(q) * 10'd10;
		return r[3:0];
	endfunction

	// x % 100 for x below 1024, reciprocal 5243 / 2^19
	function automatic logic [6:0] mod100(input logic [9:0] x);
		logic [22:0] p;
		logic [3:0]  q;
		logic [9:0]  r;
		p = 23'(x) * 23'd5243;
		q = p[22:19];
		r = x - 10'(q) * 10'd100;
		return r[6:0];
	endfunction

endpackage

FILE: rtl/multi_rate_tick_timer_unit.sv
// Multi-rate millisecond tick timer, top level.
// Pipeline: two register stages, the counter snapshot snap_s1 and the output register m_tdata.
// Throughput: one request per cycle while the output side does not stall; the counter updates at the accepting edge.
// Ready mask is evaluated one stage later from the registered counter snapshot.
// Reset (arst_n low, asynchronous): counter and enable mask cleared, pipeline emptied.
`include "multi_rate_tick_timer_unit_macros.svh"

module multi_rate_tick_timer_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,   // lapse_ms[31:0], mask_bits[37:32], zero fill
	input  logic [2:0]   s_tuser,   // req_type[2:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata    // rate_hits[5:0], consumed_ticks[15:6],
	                                // remaining_lapse[47:16], elapsed_ms[79:48],
	                                // elapsed_seconds[102:80], zero fill
);

	logic            take;
	logic            out_free;
	logic            valid_s1;
	mrtt_pkg::snap_t snap;
	mrtt_pkg::snap_t snap_s1;
	logic [5:0]      ready;
	logic            sec_edge;

	assign out_free = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || out_free;
	assign take     = s_tvalid && s_tready;

	mrtt_count u_count (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.req    (s_tuser),
		.lapse  (s_tdata[31:0]),
		.bits   (s_tdata[37:32]),
		.snap   (snap)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			snap_s1 <= snap;
		end
	end

	always_comb begin
		sec_edge = (snap_s1.ms_r == '0);
		ready = '0;
		if (snap_s1.check) begin
			ready[mrtt_pkg::RATE_1MS]   = snap_s1.en[mrtt_pkg::RATE_1MS];
			ready[mrtt_pkg::RATE_10MS]  = snap_s1.en[mrtt_pkg::RATE_10MS]
				&& (mrtt_pkg::mod10(snap_s1.ms_r) == '0);
			ready[mrtt_pkg::RATE_100MS] = snap_s1.en[mrtt_pkg::RATE_100MS]
				&& (mrtt_pkg::mod100(snap_s1.ms_r) == '0);
			ready[mrtt_pkg::RATE_1S]    = snap_s1.en[mrtt_pkg::RATE_1S] && sec_edge;
			ready[mrtt_pkg::RATE_10S]   = snap_s1.en[mrtt_pkg::RATE_10S] && sec_edge
				&& (snap_s1.sec_m10 == '0);
			ready[mrtt_pkg::RATE_1MIN]  = snap_s1.en[mrtt_pkg::RATE_1MIN] && sec_edge
				&& (snap_s1.sec_m60 == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			m_tdata <= {1'b0, snap_s1.sec, snap_s1.count, snap_s1.left, snap_s1.step, ready};
		end
	end

	`MRTT_ASSERT_IMP(a_split_count, valid_s1, (32'(snap_s1.sec) * 32'd1000 + 32'(snap_s1.ms_r)) == snap_s1.count, "seconds and residue disagree with counter")
	`MRTT_ASSERT_IMP(a_idle_fields, valid_s1 && !snap_s1.check, (snap_s1.step == '0) && (snap_s1.left == '0), "non-check request carries step or lapse")
	`MRTT_ASSERT_IMP(a_step_range, m_tvalid, m_tdata[15:6] <= 10'd1000, "consumed ticks above one second")
	`MRTT_ASSERT_NXT(a_s1_hold, valid_s1 && !out_free, valid_s1 && $stable(snap_s1), "stalled request lost or changed")

endmodule

FILE: rtl/mrtt_count.sv
// Counter and enable-mask state of the tick timer with the step logic.
// The counter is also kept as seconds plus a millisecond residue. Uses mrtt_pkg.
module mrtt_count (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [2:0]          req,
	input  logic [31:0]         lapse,
	input  logic [5:0]          bits,
	output mrtt_pkg::snap_t     snap
);

	logic [31:0] count_q, count_d;
	logic [9:0]  ms_q, ms_d;
	logic [22:0] sec_q, sec_d;
	logic [3:0]  m10_q, m10_d;
	logic [5:0]  m60_q, m60_d;
	logic [5:0]  en_q, en_d;

	logic [3:0]  r10;
	logic [6:0]  r100;
	logic [9:0]  to_edge;
	logic [9:0]  step;
	logic [32:0] sum;
	logic [10:0] ms_sum;
	logic        is_check;

	always_comb begin
		r10  = mrtt_pkg::mod10(ms_q);
		r100 = mrtt_pkg::mod100(ms_q);
		// distance to the next boundary of the finest enabled fine rate, else to the next second
		if (en_q[mrtt_pkg::RATE_1MS]) begin
			to_edge = 10'd1;
		end else if (en_q[mrtt_pkg::RATE_10MS]) begin
			to_edge = 10'd10 - 10'(r10);
		end else if (en_q[mrtt_pkg::RATE_100MS]) begin
			to_edge = 10'd100 - 10'(r100);
		end else begin
			to_edge = mrtt_pkg::MS_PER_SEC - ms_q;
		end
		step   = (lapse < 32'(to_edge)) ? lapse[9:0] : to_edge;
		sum    = {1'b0, count_q} + 33'(step);
		ms_sum = {1'b0, ms_q} + {1'b0, step};
	end

	always_comb begin
		count_d  = count_q;
		ms_d     = ms_q;
		sec_d    = sec_q;
		m10_d    = m10_q;
		m60_d    = m60_q;
		en_d     = en_q;
		is_check = 1'b0;
		case (req)
			mrtt_pkg::REQ_CHECK: begin
				is_check = 1'b1;
				count_d  = sum[31:0];
				if (sum[32]) begin
					// wrapped: the new count lies below one second
					ms_d  = sum[9:0];
					sec_d = '0;
					m10_d = '0;
					m60_d = '0;
				end else if (ms_sum >= {1'b0, mrtt_pkg::MS_PER_SEC}) begin
					ms_d  = 10'(ms_sum - {1'b0, mrtt_pkg::MS_PER_SEC});
					sec_d = sec_q + 23'd1;
					m10_d = (m10_q == mrtt_pkg::SEC_PER_10S - 4'd1) ? '0 : m10_q + 4'd1;
					m60_d = (m60_q == mrtt_pkg::SEC_PER_MIN - 6'd1) ? '0 : m60_q + 6'd1;
				end else begin
					ms_d = ms_sum[9:0];
				end
			end
			mrtt_pkg::REQ_RESTART: begin
				count_d = '0;
				ms_d    = '0;
				sec_d   = '0;
				m10_d   = '0;
				m60_d   = '0;
				en_d    = '0;
			end
			mrtt_pkg::REQ_CLEAR: begin
				count_d = '0;
				ms_d    = '0;
				sec_d   = '0;
				m10_d   = '0;
				m60_d   = '0;
			end
			mrtt_pkg::REQ_ENABLE: begin
				en_d = en_q | bits;
			end
			mrtt_pkg::REQ_DISABLE: begin
				en_d = en_q & ~bits;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ms_q    <= '0;
			sec_q   <= '0;
			m10_q   <= '0;
			m60_q   <= '0;
			en_q    <= '0;
		end else if (take) begin
			count_q <= count_d;
			ms_q    <= ms_d;
			sec_q   <= sec_d;
			m10_q   <= m10_d;
			m60_q   <= m60_d;
			en_q    <= en_d;
		end
	end

	always_comb begin
		snap.check   = is_check;
		snap.en      = en_d;
		snap.step    = is_check ? step : '0;
		snap.left    = is_check ? (lapse - 32'(step)) : '0;
		snap.count   = count_d;
		snap.ms_r    = ms_d;
		snap.sec     = sec_d;
		snap.sec_m10 = m10_d;
		snap.sec_m60 = m60_d;
	end

endmodule

FILE: tb/multi_rate_tick_timer_checker.sv
// Result checker for the multi-rate tick timer: predicts each request's result
// from its own copy of the counter and rate mask, then compares the output stream.
// Depends on mrtt_pkg for request codes and rate bit positions.
`timescale 1ns / 1ps

module multi_rate_tick_timer_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [39:0]  s_tdata,
	input  logic [2:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [103:0] m_tdata,
	output int           error_count,
	output int           awaiting,
	output int           compared,
	output int           minute_marks
);
	import mrtt_pkg::*;

	// first member sits in the top bits, so the order mirrors m_tdata from the top down
	typedef struct packed {
		logic [22:0] seconds;
		logic [31:0] ms;
		logic [31:0] left;
		logic [9:0]  ticks;
		logic [5:0]  ready;
	} tick_result_t;

	logic [31:0]  count_ms;
	logic [5:0]   rates_on;
	tick_result_t pending_results[$];

	function automatic tick_result_t timer_outcome(input logic [2:0] kind,
			input logic [31:0] lapse, input logic [5:0] bits);
		tick_result_t r;
		logic [31:0]  stride;
		r = '0;
		case (kind)
			REQ_CHECK: begin
				// step to the next boundary of the finest enabled fine rate, else the next second
				if (rates_on[RATE_1MS])
					stride = 32'd1;
				else if (rates_on[RATE_10MS])
					stride = 32'd10 - count_ms % 32'd10;
				else if (rates_on[RATE_100MS])
					stride = 32'd100 - count_ms % 32'd100;
				else
					stride = 32'd1000 - count_ms % 32'd1000;
				if (lapse < stride)
					stride = lapse;
				count_ms = count_ms + stride;
				r.ticks = stride[9:0];
				r.left = lapse - stride;
				r.ready[RATE_1MS]   = rates_on[RATE_1MS];
				r.ready[RATE_10MS]  = rates_on[RATE_10MS] && (count_ms % 32'd10 == 32'd0);
				r.ready[RATE_100MS] = rates_on[RATE_100MS] && (count_ms % 32'd100 == 32'd0);
				r.ready[RATE_1S]    = rates_on[RATE_1S] && (count_ms % 32'd1000 == 32'd0);
				r.ready[RATE_10S]   = rates_on[RATE_10S] && (count_ms % 32'd10000 == 32'd0);
				r.ready[RATE_1MIN]  = rates_on[RATE_1MIN] && (count_ms % 32'd60000 == 32'd0);
			end
			REQ_RESTART: begin
				count_ms = '0;
				rates_on = '0;
			end
			REQ_CLEAR:   count_ms = '0;
			REQ_ENABLE:  rates_on = rates_on | bits;
			REQ_DISABLE: rates_on = rates_on & ~bits;
			default: ;
		endcase
		r.ms = count_ms;
		r.seconds = 23'(count_ms / 32'd1000);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		tick_result_t got;
		tick_result_t want;
		if (!arst_n) begin
			count_ms = '0;
			rates_on = '0;
			pending_results.delete();
			error_count = 0;
			awaiting = 0;
			compared = 0;
			minute_marks = 0;
		end else begin
			if (s_tvalid && s_tready)
				pending_results.push_back(timer_outcome(s_tuser, s_tdata[31:0], s_tdata[37:32]));
			if (m_tvalid && m_tready) begin
				got = m_tdata[102:0];
				if (pending_results.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("%0t: result with no request behind it: %h", $time, m_tdata);
				end else begin
					want = pending_results.pop_front();
					compared++;
					if (got.ready !== want.ready || got.ticks !== want.ticks
							|| got.left !== want.left || got.ms !== want.ms
							|| got.seconds !== want.seconds) begin
						error_count++;
						if (error_count <= 10)
							$display({"%0t: result %0d exp/got: ready %h/%h ticks %0d/%0d",
								" left %0d/%0d ms %0d/%0d sec %0d/%0d"},
								$time, compared, want.ready, got.ready, want.ticks, got.ticks,
								want.left, got.left, want.ms, got.ms, want.seconds, got.seconds);
					end
					if (want.ready[RATE_1MIN])
						minute_marks++;
				end
			end
			awaiting = pending_results.size();
		end
	end

endmodule

FILE: tb/tb_multi_rate_tick_timer_unit.sv
// Testbench top for multi_rate_tick_timer_unit: clock, reset, request and stall stimulus.
// Depends on mrtt_pkg and on multi_rate_tick_timer_checker, which predicts and compares.
`timescale 1ns / 1ps

module tb_multi_rate_tick_timer_unit;
	import mrtt_pkg::*;

	localparam int PERIOD_NS        = 10;
	localparam int RANDOM_ITEMS     = 1250;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES    = 20;
	localparam int TIMEOUT_CYCLES   = 500000;

	// request codes the block leaves unused
	localparam logic [2:0] REQ_UNUSED_LO  = 3'd5;
	localparam logic [2:0] REQ_UNUSED_MID = 3'd6;
	localparam logic [2:0] REQ_UNUSED_HI  = 3'd7;

	localparam logic [5:0] MASK_1MS    = 6'b1 << RATE_1MS;
	localparam logic [5:0] MASK_10MS   = 6'b1 << RATE_10MS;
	localparam logic [5:0] MASK_100MS  = 6'b1 << RATE_100MS;
	localparam logic [5:0] MASK_1MIN   = 6'b1 << RATE_1MIN;
	localparam logic [5:0] MASK_FINE   = MASK_1MS | MASK_10MS | MASK_100MS;
	localparam logic [5:0] MASK_COARSE = ~MASK_FINE;
	localparam logic [5:0] MASK_ALL    = MASK_FINE | MASK_COARSE;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [39:0]  s_tdata;   // lapse_ms[31:0], mask_bits[37:32], zero fill
	logic [2:0]   s_tuser;   // req_type[2:0]
	logic         m_tvalid;
	logic         m_tready;
	logic [103:0] m_tdata;   // rate_hits[5:0], consumed_ticks[15:6], remaining_lapse[47:16],
	                         // elapsed_ms[79:48], elapsed_seconds[102:80], zero fill

	int error_count;
	int awaiting;
	int compared;
	int minute_marks;

	bit idle_tx;
	bit idle_rx;
	bit long_hold;

	int n_sent;
	int n_checks;
	int n_mask_updates;
	int n_clears;
	int n_unused;

	multi_rate_tick_timer_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	multi_rate_tick_timer_checker i_tick_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.error_count  (error_count),
		.awaiting     (awaiting),
		.compared     (compared),
		.minute_marks (minute_marks)
	);

	initial begin
		clk = 1'b0;
		forever #(PERIOD_NS / 2) clk = ~clk;
	end

	initial begin
		#(TIMEOUT_CYCLES * PERIOD_NS);
		$display("tb_multi_rate_tick_timer_unit: errors");
		$finish;
	end

	// offer one request, with an occasional idle burst first, and hold it until taken
	task automatic push_request(input logic [2:0] kind, input logic [31:0] lapse,
			input logic [5:0] bits);
		int gap;
		@(negedge clk);
		if (idle_tx && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {2'b00, bits, lapse};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		n_sent++;
		case (kind)
			REQ_CHECK:               n_checks++;
			REQ_ENABLE, REQ_DISABLE: n_mask_updates++;
			REQ_RESTART, REQ_CLEAR:  n_clears++;
			default:                 n_unused++;
		endcase
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (awaiting != 0) @(negedge clk);
	endtask

	// output side: random stall bursts, plus one long hold on request
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
				long_hold = 1'b0;
				m_tready <= 1'b1;
			end else if (idle_rx && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int          base;
		int          progress;
		int          spell;
		logic [31:0] lapse;
		logic [5:0]  off_bits;
		logic [5:0]  on_bits;
		bit          held;
		bit          drained;

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = REQ_CHECK;
		idle_tx   = 1'b0;
		idle_rx   = 1'b0;
		long_hold = 1'b0;
		held      = 1'b0;
		drained   = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// nothing enabled: zero lapse holds, full lapse steps to the next second
		push_request(REQ_CHECK, '0, '0);
		push_request(REQ_CHECK, '1, '0);
		push_request(REQ_ENABLE, '1, MASK_ALL);
		// zero lapse still reports the 1 ms rate on an unchanged counter
		push_request(REQ_CHECK, '0, MASK_ALL);
		push_request(REQ_CHECK, 32'd5, '0);
		push_request(REQ_DISABLE, '0, MASK_1MS);
		// step capped by a short lapse, then a full step to the 10 ms boundary
		push_request(REQ_CHECK, 32'd3, '0);
		push_request(REQ_CHECK, '1, '0);
		push_request(REQ_DISABLE, '1, MASK_10MS);
		push_request(REQ_CHECK, '1, MASK_ALL);
		push_request(REQ_DISABLE, '0, MASK_100MS);
		push_request(REQ_CHECK, 32'd999, '0);
		push_request(REQ_CHECK, 32'd1000, '1);
		push_request(REQ_ENABLE, '0, '0);
		push_request(REQ_DISABLE, '1, '0);
		push_request(REQ_CLEAR, '1, MASK_ALL);
		push_request(REQ_UNUSED_LO, '1, MASK_ALL);
		push_request(REQ_UNUSED_MID, '0, '0);
		push_request(REQ_UNUSED_HI, '1, MASK_ALL);
		push_request(REQ_RESTART, '1, MASK_ALL);
		push_request(REQ_CHECK, '1, MASK_ALL);
		push_request(REQ_ENABLE, '1, MASK_1MIN);
		push_request(REQ_CHECK, '1, '0);

		base = n_sent;
		while (n_sent - base < RANDOM_ITEMS) begin
			progress = n_sent - base;
			idle_tx = (progress < 500) || (progress >= 700 && progress < 1000);
			idle_rx = idle_tx;
			if (!held && progress >= 400) begin
				// stall the output for a long stretch while requests keep coming
				long_hold = 1'b1;
				held = 1'b1;
			end
			if (!drained && progress >= 850) begin
				hold_until_drained();
				drained = 1'b1;
			end

			case ($urandom_range(0, 39))
				0:       push_request(REQ_RESTART, $urandom(), 6'($urandom()));
				1, 2:    push_request(REQ_CLEAR, $urandom(), 6'($urandom()));
				default: ;
			endcase

			// pick which rate sets the step size for this spell of checks
			case ($urandom_range(0, 5))
				0, 1: begin
					off_bits = MASK_FINE;
					on_bits = MASK_COARSE;
				end
				2: begin
					off_bits = MASK_1MS | MASK_10MS;
					on_bits = MASK_100MS;
				end
				3: begin
					off_bits = MASK_1MS;
					on_bits = MASK_10MS;
				end
				4: begin
					off_bits = '0;
					on_bits = MASK_1MS;
				end
				default: begin
					off_bits = 6'($urandom());
					on_bits = 6'($urandom());
				end
			endcase
			push_request(REQ_DISABLE, $urandom(), off_bits | (6'($urandom()) & MASK_COARSE));
			push_request(REQ_ENABLE, $urandom(), on_bits | (6'($urandom()) & MASK_COARSE));

			spell = $urandom_range(5, 60);
			repeat (spell) begin
				case ($urandom_range(0, 19))
					0: push_request(3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)),
						$urandom(), 6'($urandom()));
					1: push_request($urandom_range(0, 1) ? REQ_ENABLE : REQ_DISABLE,
						$urandom(), 6'($urandom()));
					default: begin
						case ($urandom_range(0, 9))
							0:       lapse = '0;
							1, 2:    lapse = $urandom_range(1, 150);
							3, 4:    lapse = $urandom_range(1, 2000);
							default: lapse = $urandom();
						endcase
						push_request(REQ_CHECK, lapse, 6'($urandom()));
					end
				endcase
			end
		end

		hold_until_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("covered %0d requests: %0d checks, %0d mask updates, %0d restarts/clears, %0d unused",
			n_sent, n_checks, n_mask_updates, n_clears, n_unused);
		$display("compared %0d results, %0d with the 1 min rate ready, under stalls and back-pressure",
			compared, minute_marks);
		if (error_count == 0 && awaiting == 0)
			$display("tb_multi_rate_tick_timer_unit: clean");
		else
			$display("tb_multi_rate_tick_timer_unit: errors");
		$finish;
	end

endmodule
